@@ hdl/pa7u_pkg.sv @@
// Shared types and constants for the packed 7-bit text word unpacker.
package pa7u_pkg;

  localparam int CHARS_PER_WORD = 5;
  localparam int CHAR_W         = 7;
  localparam int BYTE_W         = 8;
  localparam int HIGH_W         = 32;
  localparam int WORD_W         = 36;
  localparam int COUNT_W        = 12;
  localparam int POS_W          = 3;
  localparam int IDX_W          = 3;

  localparam logic [POS_W-1:0]   LAST_HIGH_POS   = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 12'hFFF;
  localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 12'd2560;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_NUL    = 2'd1,
    KIND_LIMIT  = 2'd2,
    KIND_BADFMT = 2'd3
  } kind_t;

  // Results of one finished word: leading characters, then an optional end marker.
  typedef struct packed {
    logic [CHARS_PER_WORD-1:0][CHAR_W-1:0] chars;
    logic [IDX_W-1:0]                      num_chars;
    logic                                  has_tail;
    kind_t                                 tail_kind;
  } job_t;

endpackage

@@ hdl/pa7u_assemble.sv @@
// Word assembly, string state and result planning for each accepted byte.
module pa7u_assemble
  import pa7u_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [BYTE_W-1:0]  tape_byte,
  input  logic               start_string,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_max_chars,
  output logic               job_load,
  output job_t               job
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [HIGH_W-1:0]  high_r, high_nxt;
  logic [COUNT_W-1:0] chars_r, chars_nxt;
  logic               fin_r, fin_nxt;
  logic [COUNT_W-1:0] max_chars_r, max_chars_nxt;

  always_comb begin
    logic [POS_W-1:0]   pos_e;
    logic [HIGH_W-1:0]  high_e;
    logic [COUNT_W-1:0] chars_e;
    logic               fin_e;
    logic [WORD_W-1:0]  word;
    logic [COUNT_W:0]   sum;
    logic               found;

    pos_e   = pos_r;
    high_e  = high_r;
    chars_e = chars_r;
    fin_e   = fin_r;
    if (start_string) begin
      pos_e   = '0;
      high_e  = '0;
      chars_e = '0;
      fin_e   = 1'b0;
    end

    word  = {high_e, tape_byte[3:0]};
    found = 1'b0;
    sum   = {1'b0, chars_e} + (COUNT_W+1)'(CHARS_PER_WORD);

    job.num_chars = IDX_W'(CHARS_PER_WORD);
    job.has_tail  = 1'b0;
    job.tail_kind = KIND_CHAR;
    for (int i = 0; i < CHARS_PER_WORD; i++) begin
      job.chars[i] = word[WORD_W-1-CHAR_W*i -: CHAR_W];
      if (!found && job.chars[i] == '0) begin
        found         = 1'b1;
        job.num_chars = IDX_W'(i);
      end
    end

    job_load      = 1'b0;
    pos_nxt       = pos_r;
    high_nxt      = high_r;
    chars_nxt     = chars_r;
    fin_nxt       = fin_r;
    max_chars_nxt = cfg_we ? cfg_max_chars : max_chars_r;

    if (accept) begin
      pos_nxt   = pos_e;
      high_nxt  = high_e;
      chars_nxt = chars_e;
      fin_nxt   = fin_e;
      if (!fin_e) begin
        if (pos_e != LAST_HIGH_POS) begin
          high_nxt = {high_e[HIGH_W-BYTE_W-1:0], tape_byte};
          pos_nxt  = pos_e + POS_W'(1);
        end else begin
          pos_nxt  = '0;
          job_load = 1'b1;
          if (tape_byte[7:4] != 4'd0) begin
            fin_nxt       = 1'b1;
            job.num_chars = '0;
            job.has_tail  = 1'b1;
            job.tail_kind = KIND_BADFMT;
          end else if (found) begin
            fin_nxt       = 1'b1;
            job.has_tail  = 1'b1;
            job.tail_kind = KIND_NUL;
          end else begin
            chars_nxt = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
            if (chars_nxt >= max_chars_r) begin
              fin_nxt       = 1'b1;
              job.has_tail  = 1'b1;
              job.tail_kind = KIND_LIMIT;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      high_r      <= '0;
      chars_r     <= '0;
      fin_r       <= 1'b1;
      max_chars_r <= MAX_CHARS_RESET;
    end else begin
      pos_r       <= pos_nxt;
      high_r      <= high_nxt;
      chars_r     <= chars_nxt;
      fin_r       <= fin_nxt;
      max_chars_r <= max_chars_nxt;
    end
  end

endmodule

@@ hdl/pa7u_emit.sv @@
// Result sequencer: holds one word's plan and sends its results one beat at a time.
module pa7u_emit
  import pa7u_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_load,
  input  job_t              job,
  output logic              job_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_character,
  output logic [1:0]        out_kind,
  output logic              out_last
);

  job_t              job_r, job_nxt;
  logic              job_valid_r, job_valid_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  kind_t             kind_r, kind_nxt;
  logic              last_r, last_nxt;

  logic [IDX_W-1:0]  total;
  logic              last_res;
  logic              take;

  always_comb begin
    total    = job_r.num_chars + IDX_W'(job_r.has_tail);
    last_res = idx_r == total - IDX_W'(1);
    take     = job_valid_r && (!out_valid_r || out_ready);
    job_ready = !job_valid_r || (take && last_res);

    char_nxt = char_r;
    kind_nxt = kind_r;
    last_nxt = last_r;
    if (take) begin
      last_nxt = last_res;
      if (idx_r < job_r.num_chars) begin
        kind_nxt = KIND_CHAR;
        case (idx_r)
          3'd0:    char_nxt = job_r.chars[0];
          3'd1:    char_nxt = job_r.chars[1];
          3'd2:    char_nxt = job_r.chars[2];
          3'd3:    char_nxt = job_r.chars[3];
          3'd4:    char_nxt = job_r.chars[4];
          default: char_nxt = '0;
        endcase
      end else begin
        kind_nxt = job_r.tail_kind;
        char_nxt = '0;
      end
    end

    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    idx_nxt       = idx_r;
    if (job_load) begin
      job_nxt       = job;
      job_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (take) begin
      if (last_res) begin
        job_valid_nxt = 1'b0;
      end
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    char_r <= char_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_kind      = kind_r;
  assign out_last      = last_r;

endmodule

@@ hdl/packed_ascii7_word_unpacker_core.sv @@
// Top level of the packed 7-bit text word unpacker.
// Bytes one to four of a word are shifted into the high register and give no beat.
// The fifth byte loads the word's plan into the job register, from which its first result moves to the output register.
// Results then leave at one beat per cycle while out_ready is high; the input stalls until the word's last one loads.
// A word of n results passes all of them through the single result register.
// Synchronous active-low reset idles the string until a start flag and restores the limit to 2560.
module packed_ascii7_word_unpacker_core
  import pa7u_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_tape_byte,
  input  logic               in_start_string,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_character,
  output logic [1:0]         out_kind,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [11:0]        cfg_max_chars
);

  logic job_load;
  job_t job;
  logic accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  pa7u_assemble u_assemble (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .tape_byte    (in_tape_byte),
    .start_string (in_start_string),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_max_chars(cfg_max_chars),
    .job_load     (job_load),
    .job          (job)
  );

  pa7u_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_load     (job_load),
    .job          (job),
    .job_ready    (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_kind     (out_kind),
    .out_last     (out_last)
  );

  a_end_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_CHAR) |-> out_last)
    else $error("end marker beat without last");

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_load |-> (job.num_chars <= 3'd5 && (job.num_chars != 3'd0 || job.has_tail)))
    else $error("word plan with no results");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
